@@ rtl/fpa_pkg.sv @@
// Shared types, constants and helpers for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DW        = 32;            // word width
  localparam int FB        = 8;             // fraction bits
  localparam int CMD_W     = 4;
  localparam int NQ_W      = DW + FB;       // divider numerator / quotient width
  localparam int DIV_STEPS = NQ_W;          // one quotient bit per stage
  localparam int NST       = DIV_STEPS + 1; // front stage plus divider stages
  localparam int MAG_W     = 2 * DW + 1;    // widest magnitude handed to saturation

  localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MIN = 4'd4,
    CMD_MAX = 4'd5,
    CMD_INC = 4'd6,
    CMD_DEC = 4'd7,
    CMD_I2F = 4'd8,
    CMD_F2I = 4'd9
  } cmd_e;

  // One item as it travels down the pipeline
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              neg;
    logic [DW-1:0]     simple;
    logic              simple_ovf;
    logic              dz;
    logic              lt;
    logic              eq;
    logic              gt;
    logic [DW-1:0]     ma;
    logic [DW-1:0]     mb;
    logic [2*DW-1:0]   prod;
    logic [DW-1:0]     rem;
    logic [NQ_W-1:0]   nq;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] res;
    logic          ovf;
  } sat_t;

  // Turn a sign and a magnitude into a saturated word
  function automatic sat_t sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lim_neg;
    logic [MAG_W-1:0] twos;
    sat_t             r;
    lim_neg = {{(MAG_W-DW){1'b0}}, WORD_MIN};
    twos    = ~mag + {{(MAG_W-1){1'b0}}, 1'b1};
    r.ovf   = 1'b0;
    r.res   = mag[DW-1:0];
    if (neg) begin
      if (mag > lim_neg) begin
        r.ovf = 1'b1;
        r.res = WORD_MIN;
      end else begin
        r.res = twos[DW-1:0];
      end
    end else if (mag > (lim_neg - {{(MAG_W-1){1'b0}}, 1'b1})) begin
      r.ovf = 1'b1;
      r.res = WORD_MAX;
    end
    return r;
  endfunction

endpackage

@@ rtl/fpa_front.sv @@
// Front stage: decode, compare flags, simple-command results and divider setup.
`timescale 1ns / 1ps
module fpa_front
  import fpa_pkg::*;
(
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [DW-1:0]    a_i,
  input  logic [DW-1:0]    b_i,
  output item_t            item_o
);

  logic          na, nb;
  logic [DW-1:0] ma, mb;
  logic [DW-1:0] sum, diff, inc, dec, sat_a, f2i;
  logic          sum_ovf, diff_ovf, i2f_fits;
  logic [FB:0]   top_a;

  // Magnitudes and plain arithmetic
  always_comb begin
    na       = a_i[DW-1];
    nb       = b_i[DW-1];
    ma       = na ? (~a_i + {{(DW-1){1'b0}}, 1'b1}) : a_i;
    mb       = nb ? (~b_i + {{(DW-1){1'b0}}, 1'b1}) : b_i;
    sum      = a_i + b_i;
    diff     = a_i - b_i;
    inc      = a_i + {{(DW-1){1'b0}}, 1'b1};
    dec      = a_i - {{(DW-1){1'b0}}, 1'b1};
    sum_ovf  = (a_i[DW-1] == b_i[DW-1]) && (sum[DW-1] != a_i[DW-1]);
    diff_ovf = (a_i[DW-1] != b_i[DW-1]) && (diff[DW-1] != a_i[DW-1]);
    sat_a    = na ? WORD_MIN : WORD_MAX;
    top_a    = a_i[DW-1 -: FB+1];
    i2f_fits = (&top_a) || !(|top_a);
    f2i      = DW'($signed(a_i) >>> FB);
  end

  // Build the pipeline item
  always_comb begin
    item_o            = '0;
    item_o.cmd        = cmd_i;
    item_o.neg        = na ^ nb;
    item_o.lt         = $signed(a_i) < $signed(b_i);
    item_o.eq         = a_i == b_i;
    item_o.gt         = $signed(a_i) > $signed(b_i);
    item_o.ma         = ma;
    item_o.mb         = mb;
    item_o.rem        = '0;
    item_o.nq         = {ma, {FB{1'b0}}};
    item_o.dz         = (cmd_i == CMD_DIV) && (b_i == '0);
    case (cmd_i)
      CMD_ADD: begin
        item_o.simple     = sum_ovf ? sat_a : sum;
        item_o.simple_ovf = sum_ovf;
      end
      CMD_SUB: begin
        item_o.simple     = diff_ovf ? sat_a : diff;
        item_o.simple_ovf = diff_ovf;
      end
      CMD_MIN: item_o.simple = ($signed(a_i) <= $signed(b_i)) ? a_i : b_i;
      CMD_MAX: item_o.simple = ($signed(a_i) <= $signed(b_i)) ? b_i : a_i;
      CMD_INC: begin
        item_o.simple     = (a_i == WORD_MAX) ? WORD_MAX : inc;
        item_o.simple_ovf = a_i == WORD_MAX;
      end
      CMD_DEC: begin
        item_o.simple     = (a_i == WORD_MIN) ? WORD_MIN : dec;
        item_o.simple_ovf = a_i == WORD_MIN;
      end
      CMD_I2F: begin
        item_o.simple     = i2f_fits ? (a_i << FB) : sat_a;
        item_o.simple_ovf = !i2f_fits;
      end
      CMD_F2I: item_o.simple = f2i;
      default: item_o.simple = '0;
    endcase
  end

endmodule

@@ rtl/fpa_div_step.sv @@
// One restoring-division step: one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module fpa_div_step
  import fpa_pkg::*;
(
  input  item_t item_i,
  output item_t item_o
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // Shift in the next numerator bit and try to subtract the divisor
  always_comb begin
    trial       = {item_i.rem, item_i.nq[NQ_W-1]};
    diff        = trial - {1'b0, item_i.mb};
    ge          = trial >= {1'b0, item_i.mb};
    item_o      = item_i;
    item_o.rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
    item_o.nq   = {item_i.nq[NQ_W-2:0], ge};
  end

endmodule

@@ rtl/fpa_final.sv @@
// Final stage: round and saturate multiply and divide, select the result.
`timescale 1ns / 1ps
module fpa_final
  import fpa_pkg::*;
(
  input  item_t         item_i,
  output logic [DW-1:0] res_o,
  output logic          ovf_o
);

  logic [2*DW:0]  mul_rnd;
  logic           rnd_up;
  logic [NQ_W:0]  quo;
  sat_t           mul_sat, div_sat;

  // Round half away from zero on magnitudes, then saturate
  always_comb begin
    mul_rnd = {1'b0, item_i.prod} + {{(2*DW-FB+1){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    mul_sat = sat_mag(item_i.neg, MAG_W'(mul_rnd[2*DW:FB]));
    rnd_up  = {item_i.rem, 1'b0} >= {1'b0, item_i.mb};
    quo     = {1'b0, item_i.nq} + {{NQ_W{1'b0}}, rnd_up};
    div_sat = sat_mag(item_i.neg, MAG_W'(quo));
  end

  // Pick the result for the command
  always_comb begin
    case (item_i.cmd)
      CMD_MUL: begin
        res_o = mul_sat.res;
        ovf_o = mul_sat.ovf;
      end
      CMD_DIV: begin
        res_o = item_i.dz ? '0 : div_sat.res;
        ovf_o = !item_i.dz && div_sat.ovf;
      end
      default: begin
        res_o = item_i.simple;
        ovf_o = item_i.simple_ovf;
      end
    endcase
  end

endmodule

@@ rtl/fixed_point_q24_8_alu.sv @@
// Top level of the pipelined Q24.8 fixed-point ALU.
// Signed Q24.8 ALU: add, sub, mul, div, min, max, inc, dec, int-to-fixed and
// fixed-to-int, with less/equal/greater flags for a against b on every result.
// One transaction is accepted per cycle while the output is not stalled, and
// each gives exactly one result, registered through a front stage, 40 divider
// stages (one quotient bit each, so the divider depth sets the latency for
// every command) and the output register.
// Multiply and divide round half away from zero; results outside 32 bits
// saturate and set overflowed; divide by zero returns 0 with divided_by_zero.
// The whole pipeline moves whenever the output register is empty or drains;
// a stalled output holds every stage and the input.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu
  import fpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [2*DW-1:0]   s_axis_tdata_i,  // operand_a, operand_b
  input  logic [CMD_W-1:0]  s_axis_tuser_i,  // command
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DW-1:0]     m_axis_tdata_o,  // result_raw
  output logic [4:0]        m_axis_tuser_o   // a_less, a_equal, a_greater,
                                             // overflowed, divided_by_zero
);

  item_t         item_q [NST];
  item_t         item_d [NST];
  logic          valid_q [NST];
  logic          adv;
  logic          out_valid_q;
  logic [DW-1:0] out_data_q;
  logic [4:0]    out_user_q;
  logic [DW-1:0] fin_res;
  logic          fin_ovf;

  // Advance when the output register is empty or is being drained
  assign adv = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  fpa_front u_front (
    .cmd_i  (s_axis_tuser_i),
    .a_i    (s_axis_tdata_i[DW-1:0]),
    .b_i    (s_axis_tdata_i[2*DW-1:DW]),
    .item_o (item_d[0])
  );

  // Divider stages; the first one also forms the magnitude product
  for (genvar k = 1; k < NST; k++) begin : g_step
    item_t step_out;
    fpa_div_step u_step (
      .item_i (item_q[k-1]),
      .item_o (step_out)
    );
    if (k == 1) begin : g_mul
      always_comb begin
        item_d[k]      = step_out;
        item_d[k].prod = item_q[k-1].ma * item_q[k-1].mb;
      end
    end else begin : g_pass
      assign item_d[k] = step_out;
    end
  end

  // Hold or advance the stage registers
  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv) begin
        valid_q[k] <= (k == 0) ? s_axis_tvalid_i : valid_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        item_q[k] <= item_d[k];
      end
    end
  end

  fpa_final u_final (
    .item_i (item_q[NST-1]),
    .res_o  (fin_res),
    .ovf_o  (fin_ovf)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_q[NST-1]) begin
      out_data_q <= fin_res;
      out_user_q <= {item_q[NST-1].dz, fin_ovf, item_q[NST-1].gt,
                     item_q[NST-1].eq, item_q[NST-1].lt};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ dv/fixed_point_q24_8_alu_test.sv @@
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_test;
  import fpa_pkg::*;

  typedef struct packed {
    logic [DW-1:0] res;
    logic          lt;
    logic          eq;
    logic          gt;
    logic          ovf;
    logic          dz;
  } alu_out_t;

  // Exact integer model of one ALU operation
  function automatic alu_out_t compute_alu(logic [CMD_W-1:0] cmd, logic signed [DW-1:0] a,
                                           logic signed [DW-1:0] b);
    alu_out_t         o;
    logic signed [127:0] wa, wb, r, lim_hi, lim_lo;
    logic [127:0]     mag_a, mag_b, mag, qq, rr;
    logic             neg, sat;
    wa = a;
    wb = b;
    lim_hi = 128'sh7FFFFFFF;
    lim_lo = -128'sh80000000;
    o = '0;
    o.lt = a < b;
    o.eq = a == b;
    o.gt = a > b;
    mag_a = wa < 0 ? -wa : wa;
    mag_b = wb < 0 ? -wb : wb;
    neg = (wa < 0) != (wb < 0);
    sat = 1'b1;
    r = 0;
    case (cmd)
      CMD_ADD: r = wa + wb;
      CMD_SUB: r = wa - wb;
      CMD_MUL: begin
        mag = (mag_a * mag_b + (128'd1 << (FB - 1))) >> FB;
        r = neg ? -$signed(mag) : $signed(mag);
      end
      CMD_DIV: begin
        if (b == 0) begin
          o.dz = 1'b1;
          sat = 1'b0;
        end else begin
          qq = (mag_a << FB) / mag_b;
          rr = (mag_a << FB) % mag_b;
          if (rr >= mag_b - rr) qq = qq + 1;
          r = neg ? -$signed(qq) : $signed(qq);
        end
      end
      CMD_MIN: r = (a <= b) ? wa : wb;
      CMD_MAX: r = (a <= b) ? wb : wa;
      CMD_INC: r = wa + 1;
      CMD_DEC: r = wa - 1;
      CMD_I2F: r = wa * 256;
      CMD_F2I: r = wa >>> FB;
      default: sat = 1'b0;
    endcase
    if (sat && r > lim_hi) begin
      o.ovf = 1'b1;
      r = lim_hi;
    end else if (sat && r < lim_lo) begin
      o.ovf = 1'b1;
      r = lim_lo;
    end
    o.res = r[DW-1:0];
    return o;
  endfunction

  class alu_scoreboard;
    alu_out_t pending[$];
    int       n_errors;
    int       n_checked;

    function void note_input(logic [CMD_W-1:0] cmd, logic [DW-1:0] a, logic [DW-1:0] b);
      pending.push_back(compute_alu(cmd, a, b));
    endfunction

    function void check_result(logic [DW-1:0] data, logic [4:0] flags);
      alu_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result data=%h flags=%b", data, flags);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (data !== e.res) begin
        $error("result_raw exp %h act %h", e.res, data); n_errors++;
      end
      if (flags[0] !== e.lt) begin
        $error("a_less exp %b act %b", e.lt, flags[0]); n_errors++;
      end
      if (flags[1] !== e.eq) begin
        $error("a_equal exp %b act %b", e.eq, flags[1]); n_errors++;
      end
      if (flags[2] !== e.gt) begin
        $error("a_greater exp %b act %b", e.gt, flags[2]); n_errors++;
      end
      if (flags[3] !== e.ovf) begin
        $error("overflowed exp %b act %b", e.ovf, flags[3]); n_errors++;
      end
      if (flags[4] !== e.dz) begin
        $error("divided_by_zero exp %b act %b", e.dz, flags[4]); n_errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [2*DW-1:0]  s_axis_tdata_i = '0;
  logic [CMD_W-1:0] s_axis_tuser_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DW-1:0]    m_axis_tdata_o;
  logic [4:0]       m_axis_tuser_o;

  alu_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  n_sent;

  fixed_point_q24_8_alu i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_op(logic [CMD_W-1:0] cmd, logic [DW-1:0] a, logic [DW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(cmd, a, b);
    n_sent++;
  endtask

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(7))
      0: return WORD_MAX - $urandom_range(3);
      1: return WORD_MIN + $urandom_range(3);
      2: return $urandom_range(1023) - 512;
      3: return $signed($urandom_range(65535)) - 32768;
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int count);
    logic [CMD_W-1:0] cmd;
    logic [DW-1:0] a, b;
    repeat (count) begin
      cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(15)) :
                                        CMD_W'($urandom_range(9));
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? a : pick_operand();
      send_op(cmd, a, b);
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: every command, range ends, rounding ties, divide by zero
    for (int c = 0; c < 10; c++) send_op(CMD_W'(c), WORD_MAX, WORD_MIN);
    send_op(CMD_ADD, WORD_MIN, WORD_MIN);
    send_op(CMD_SUB, WORD_MAX, 32'hFFFFFFFF);
    send_op(CMD_MUL, 32'h00000180, 32'hFFFFFF80);
    send_op(CMD_MUL, 32'h00000001, 32'h00000080);
    send_op(CMD_MUL, WORD_MIN, WORD_MIN);
    send_op(CMD_DIV, 32'h00000100, 32'h00000000);
    send_op(CMD_DIV, 32'h00000001, 32'hFFFFFE00);
    send_op(CMD_DIV, WORD_MIN, 32'h00000001);
    send_op(CMD_DIV, WORD_MIN, 32'hFFFFFFFF);
    send_op(CMD_MIN, 32'h5, 32'h5);
    send_op(CMD_INC, WORD_MAX, 32'h0);
    send_op(CMD_DEC, WORD_MIN, 32'h0);
    send_op(CMD_I2F, 32'hFF800000, 32'h0);
    send_op(CMD_F2I, 32'hFFFFFF01, 32'h0);
    send_op(4'd12, 32'h1, 32'h2);
    s_axis_tvalid_i <= 1'b0;

    // Long hold-off on the output while the sender keeps pushing
    hold_off = 1'b1;
    fork
      send_random(80);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join

    send_random(190);
    send_idle_pct = 53;
    send_random(190);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    send_random(190);
    send_idle_pct = 35;
    recv_stall_pct = 35;
    send_random(190);

    drain();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d operations over all ten commands plus unused codes;", n_sent);
    $display("checked %0d results under idle, stall and back-pressure phases.",
             sb.n_checked);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
